// ===== hw/rtl/tdp_pkg.sv =====
package tdp_pkg;

  // Default candidate width
  localparam int NUMBER_WIDTH_DEF = 16;

  // Result stream data width: is_prime padded to one byte
  localparam int OUT_TDATA_W = 8;

  // Program counter width and step addresses
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] STEP_SMALL    = 4'd1;
  localparam logic [PC_W-1:0] STEP_BOUND    = 4'd2;
  localparam logic [PC_W-1:0] STEP_DIV      = 4'd3;
  localparam logic [PC_W-1:0] STEP_DIV_WAIT = 4'd4;
  localparam logic [PC_W-1:0] STEP_REM      = 4'd5;
  localparam logic [PC_W-1:0] STEP_NEXT     = 4'd6;
  localparam logic [PC_W-1:0] STEP_EMIT0    = 4'd7;
  localparam logic [PC_W-1:0] STEP_RET0     = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMIT1    = 4'd9;
  localparam logic [PC_W-1:0] STEP_RET1     = 4'd10;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_LOAD  = 3'd1,
    OP_DIV   = 3'd2,
    OP_STEP  = 3'd3,
    OP_EMIT0 = 3'd4,
    OP_EMIT1 = 3'd5
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_IN    = 3'd2,
    C_LT2      = 3'd3,
    C_SQ_GT    = 3'd4,
    C_DIV_BUSY = 3'd5,
    C_REM_ZERO = 3'd6,
    C_OUT_BUSY = 3'd7
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic no_in;
    logic lt2;
    logic sq_gt;
    logic div_busy;
    logic rem_zero;
    logic out_busy;
  } tdp_flags_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_t op;
  } tdp_ctrl_t;

  // Microprogram: jump to target when cond holds, else fall through
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t uw;
    uw = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_WAIT};
    case (pc)
      STEP_WAIT:     uw = '{op: OP_LOAD,  cond: C_NO_IN,    target: STEP_WAIT};
      STEP_SMALL:    uw = '{op: OP_NOP,   cond: C_LT2,      target: STEP_EMIT0};
      STEP_BOUND:    uw = '{op: OP_NOP,   cond: C_SQ_GT,    target: STEP_EMIT1};
      STEP_DIV:      uw = '{op: OP_DIV,   cond: C_NEVER,    target: STEP_WAIT};
      STEP_DIV_WAIT: uw = '{op: OP_NOP,   cond: C_DIV_BUSY, target: STEP_DIV_WAIT};
      STEP_REM:      uw = '{op: OP_NOP,   cond: C_REM_ZERO, target: STEP_EMIT0};
      STEP_NEXT:     uw = '{op: OP_STEP,  cond: C_ALWAYS,   target: STEP_BOUND};
      STEP_EMIT0:    uw = '{op: OP_EMIT0, cond: C_OUT_BUSY, target: STEP_EMIT0};
      STEP_RET0:     uw = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_WAIT};
      STEP_EMIT1:    uw = '{op: OP_EMIT1, cond: C_OUT_BUSY, target: STEP_EMIT1};
      STEP_RET1:     uw = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_WAIT};
      default:       uw = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_WAIT};
    endcase
    return uw;
  endfunction

endpackage

// ===== hw/rtl/tdp_rem.sv =====
module tdp_rem
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output logic                    busy,
  output logic                    rem_zero
);

  localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

  logic [CNT_W-1:0]        cnt;
  logic [NUMBER_WIDTH-1:0] quo;
  logic [NUMBER_WIDTH-1:0] rem;
  logic [NUMBER_WIDTH:0]   rem_shift;
  logic [NUMBER_WIDTH:0]   rem_diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem, quo[NUMBER_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign busy      = (cnt != '0);
  assign rem_zero  = (rem == '0);

  // Count steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUMBER_WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NUMBER_WIDTH-2:0], 1'b0};
      if (rem_diff[NUMBER_WIDTH]) begin
        rem <= rem_shift[NUMBER_WIDTH-1:0];
      end else begin
        rem <= rem_diff[NUMBER_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/tdp_seq.sv =====
module tdp_seq
  import tdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  tdp_flags_t flags,
  output tdp_ctrl_t  ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            taken;

  assign uw      = ucode_rom(pc);
  assign ctrl.op = uw.op;

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_IN:    taken = flags.no_in;
      C_LT2:      taken = flags.lt2;
      C_SQ_GT:    taken = flags.sq_gt;
      C_DIV_BUSY: taken = flags.div_busy;
      C_REM_ZERO: taken = flags.rem_zero;
      C_OUT_BUSY: taken = flags.out_busy;
      default:    taken = 1'b1;
    endcase
  end

  assign pc_next = taken ? uw.target : pc + 1'b1;

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hw/rtl/trial_division_primality_test.sv =====
// Tests one candidate per item by trial division with divisors 2, 3, ... while d*d <= n.
// Each of the k trial divisors, k <= floor(sqrt(n))-1, costs one pass of the bit-serial
// remainder unit; one item is in work at a time.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst, synchronous) returns the sequencer to its wait step and empties the output.
module trial_division_primality_test
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]      s_tdata,  // [NUMBER_WIDTH-1:0] candidate
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [OUT_TDATA_W-1:0]                 m_tdata   // [0] is_prime
);

  tdp_ctrl_t  ctrl;
  tdp_flags_t flags;

  logic [NUMBER_WIDTH-1:0] n;
  logic [NUMBER_WIDTH-1:0] d;
  logic [NUMBER_WIDTH:0]   sq;
  logic                    is_prime;
  logic                    div_busy;
  logic                    rem_zero;
  logic                    load;
  logic                    emit;
  logic                    out_busy;

  tdp_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  tdp_rem #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.op == OP_DIV),
    .dividend (n),
    .divisor  (d),
    .busy     (div_busy),
    .rem_zero (rem_zero)
  );

  assign s_tready = (ctrl.op == OP_LOAD);
  assign load     = s_tready & s_tvalid;
  assign out_busy = m_tvalid & ~m_tready;
  assign emit     = ((ctrl.op == OP_EMIT0) || (ctrl.op == OP_EMIT1)) & ~out_busy;

  // Status for the sequencer
  assign flags.no_in    = ~s_tvalid;
  assign flags.lt2      = (n[NUMBER_WIDTH-1:1] == '0);
  assign flags.sq_gt    = (sq > {1'b0, n});
  assign flags.div_busy = div_busy;
  assign flags.rem_zero = rem_zero;
  assign flags.out_busy = out_busy;

  // Candidate, divisor and divisor square: (d+1)^2 = d^2 + 2d + 1
  always_ff @(posedge clk) begin
    if (load) begin
      n  <= s_tdata[NUMBER_WIDTH-1:0];
      d  <= NUMBER_WIDTH'(2);
      sq <= (NUMBER_WIDTH+1)'(4);
    end else if (ctrl.op == OP_STEP) begin
      d  <= d + 1'b1;
      sq <= sq + {d, 1'b0} + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_prime <= (ctrl.op == OP_EMIT1);
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, is_prime};

`ifndef SYNTH
  // Remainder unit is idle whenever a new item can be taken
  a_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("remainder unit busy while taking an item");

  // A division only starts for a candidate of at least 2 within the bound
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV) |-> (!flags.lt2 && !flags.sq_gt))
    else $error("division started outside the search range");

  // Trial divisor never drops below 2 during a division
  a_div_min: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (d >= NUMBER_WIDTH'(2)))
    else $error("trial divisor below 2");

  // A result appears only after an emit step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctrl.op == OP_EMIT0 || ctrl.op == OP_EMIT1))
    else $error("result shown without an emit step");
`endif

endmodule
